// File: design/pig_pkg.sv
// shared constants, types and helper functions for the prime implicant generator
package pig_pkg;

	localparam int MAX_VARS    = 4;
	localparam int NUM_MINT    = 1 << MAX_VARS;
	localparam int VAR_W       = MAX_VARS;
	localparam int TT_W        = 16;
	localparam int NV_W        = 3;
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = $clog2(MAX_RESULTS);
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [NV_W-1:0] NUM_VARS_RESET = NV_W'(4);

	// register indexes
	localparam logic [PADDR_W-3:0] REG_NUM_VARS = '0;

	typedef enum logic [1:0] {
		KIND_IMPL = 2'd0,
		KIND_ZERO = 2'd1,
		KIND_ONE  = 2'd2
	} kind_t;

	// cube grid, indexed [mask][value]
	typedef logic [NUM_MINT-1:0][NUM_MINT-1:0] grid_t;

	typedef struct packed {
		kind_t kind;
		grid_t prime;
	} pig_item_t;

	function automatic logic [NV_W-1:0] clamp_nv(input logic [NV_W-1:0] nv);
		logic [NV_W-1:0] r;
		if (nv == '0)
			r = NV_W'(1);
		else if (nv > NV_W'(MAX_VARS))
			r = NV_W'(MAX_VARS);
		else
			r = nv;
		return r;
	endfunction

	// variables in use as a bit mask
	function automatic logic [VAR_W-1:0] var_mask(input logic [NV_W-1:0] nv);
		logic [VAR_W-1:0] r;
		r = '0;
		for (int i = 0; i < VAR_W; i++)
			if (NV_W'(i) < nv)
				r[i] = 1'b1;
		return r;
	endfunction

	// minterms in use as a table mask
	function automatic logic [TT_W-1:0] table_mask(input logic [VAR_W-1:0] vm);
		logic [TT_W-1:0] r;
		r = '0;
		for (int t = 0; t < NUM_MINT; t++)
			if ((VAR_W'(t) & ~vm) == '0)
				r[t] = 1'b1;
		return r;
	endfunction

	// minterms covered by cube (v, m)
	function automatic logic [TT_W-1:0] cover_bits(input logic [VAR_W-1:0] v,
			input logic [VAR_W-1:0] m);
		logic [TT_W-1:0] r;
		r = '0;
		for (int t = 0; t < NUM_MINT; t++)
			if ((VAR_W'(t) & ~m) == v)
				r[t] = 1'b1;
		return r;
	endfunction

	// index of lowest set bit
	function automatic logic [VAR_W-1:0] low_one(input logic [NUM_MINT-1:0] x);
		logic [VAR_W-1:0] r;
		r = '0;
		for (int i = NUM_MINT - 1; i >= 0; i--)
			if (x[i])
				r = VAR_W'(i);
		return r;
	endfunction

endpackage

// File: design/pig_in_if.sv
// request channel carrying one truth table
interface pig_in_if import pig_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [TT_W-1:0] truth_table;

	modport source (output valid, output truth_table, input ready);
	modport sink   (input valid, input truth_table, output ready);
endinterface

// File: design/pig_out_if.sv
// result channel carrying one implicant
interface pig_out_if import pig_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [VAR_W-1:0] term_value;
	logic [VAR_W-1:0] term_mask;
	logic [1:0]       term_kind;
	logic             last_term;

	modport source (output valid, output term_value, output term_mask,
		output term_kind, output last_term, input ready);
	modport sink   (input valid, input term_value, input term_mask,
		input term_kind, input last_term, output ready);
endinterface

// File: design/pig_cfg.sv
// configuration register file behind the apb port
module pig_cfg import pig_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [NV_W-1:0]    num_vars
);
	logic [NV_W-1:0]    num_vars_q;
	logic [PADDR_W-3:0] reg_idx;
	logic               wr_en;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && (reg_idx == REG_NUM_VARS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q <= NUM_VARS_RESET;
		end else if (wr_en) begin
			num_vars_q <= pwdata[NV_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_NUM_VARS)
			prdata = PDATA_W'(num_vars_q);
	end

	assign num_vars = num_vars_q;
endmodule

// File: design/pig_cube.sv
// three stage cube analysis: table prep, implicant grid, prime grid
module pig_cube import pig_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [NV_W-1:0] num_vars,
	pig_in_if.sink          req_in,
	output logic            item_valid,
	input  logic            item_ready,
	output pig_item_t       item
);
	logic             valid_s1, valid_s2, valid_s3;
	logic             adv1, adv2, adv3;
	logic [TT_W-1:0]  table_s1;
	logic [VAR_W-1:0] vmask_s1;
	kind_t            kind_s1, kind_s2, kind_s3;
	grid_t            present_s2, prime_s3;

	logic [VAR_W-1:0] vmask_in;
	logic [TT_W-1:0]  tmask_in, table_in;
	kind_t            kind_in;
	grid_t            present_c, prime_c;

	assign adv3         = !valid_s3 || item_ready;
	assign adv2         = !valid_s2 || adv3;
	assign adv1         = !valid_s1 || adv2;
	assign req_in.ready = adv1;

	// stage 1: clamp, mask the table, spot constant functions
	always_comb begin
		vmask_in = var_mask(clamp_nv(num_vars));
		tmask_in = table_mask(vmask_in);
		table_in = req_in.truth_table & tmask_in;
		if (table_in == '0)
			kind_in = KIND_ZERO;
		else if (table_in == tmask_in)
			kind_in = KIND_ONE;
		else
			kind_in = KIND_IMPL;
	end

	// stage 2: a cube is an implicant when every minterm it covers is one
	always_comb begin
		for (int m = 0; m < NUM_MINT; m++)
			for (int v = 0; v < NUM_MINT; v++)
				present_c[m][v] = ((VAR_W'(m) & VAR_W'(v)) == '0)
					&& (((VAR_W'(m) | VAR_W'(v)) & ~vmask_s1) == '0)
					&& (&(table_s1 | ~cover_bits(VAR_W'(v), VAR_W'(m))));
	end

	// stage 3: prime when no one-variable widening is still an implicant
	always_comb begin
		for (int m = 0; m < NUM_MINT; m++)
			for (int v = 0; v < NUM_MINT; v++) begin
				prime_c[m][v] = present_s2[m][v];
				for (int b = 0; b < VAR_W; b++)
					if (!m[b] && present_s2[m | (1 << b)][v & ~(1 << b)])
						prime_c[m][v] = 1'b0;
			end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1)
				valid_s1 <= req_in.valid;
			if (adv2)
				valid_s2 <= valid_s1;
			if (adv3)
				valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && req_in.valid) begin
			table_s1 <= table_in;
			vmask_s1 <= vmask_in;
			kind_s1  <= kind_in;
		end
		if (adv2 && valid_s1) begin
			present_s2 <= present_c;
			kind_s2    <= kind_s1;
		end
		if (adv3 && valid_s2) begin
			prime_s3 <= prime_c;
			kind_s3  <= kind_s2;
		end
	end

	assign item_valid = valid_s3;
	assign item.kind  = kind_s3;
	assign item.prime = prime_s3;
endmodule

// File: design/pig_emit.sv
// prime serializer with output register
module pig_emit import pig_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  pig_item_t item,
	pig_out_if.source res_out
);
	logic                busy_q;
	kind_t               kind_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [NUM_MINT-1:0] grp_q [NUM_MINT];

	logic                ov_q;
	logic [VAR_W-1:0]    oval_q, omask_q;
	kind_t               okind_q;
	logic                olast_q;

	logic [NUM_MINT-1:0] nonempty, row, rest_rows, rest_bits;
	logic [VAR_W-1:0]    gm, gv;
	logic                is_last, load_out, take;

	always_comb begin
		for (int m = 0; m < NUM_MINT; m++)
			nonempty[m] = |grp_q[m];
		gm        = low_one(nonempty);
		row       = grp_q[gm];
		gv        = low_one(row);
		rest_rows = nonempty & ~(NUM_MINT'(1) << gm);
		rest_bits = row & ~(NUM_MINT'(1) << gv);
		is_last   = (kind_q != KIND_IMPL) || (cnt_q == CNT_W'(MAX_RESULTS - 1))
			|| ((rest_rows == '0) && (rest_bits == '0));
	end

	assign load_out   = busy_q && (!ov_q || res_out.ready);
	assign take       = !busy_q || (load_out && is_last);
	assign item_ready = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (take)
				busy_q <= item_valid;
			if (load_out)
				ov_q <= 1'b1;
			else if (res_out.ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_valid) begin
			kind_q <= item.kind;
			cnt_q  <= '0;
			for (int m = 0; m < NUM_MINT; m++)
				grp_q[m] <= item.prime[m];
		end else if (load_out) begin
			cnt_q          <= cnt_q + CNT_W'(1);
			grp_q[gm][gv] <= 1'b0;
		end
		if (load_out) begin
			okind_q <= kind_q;
			olast_q <= is_last;
			if (kind_q == KIND_IMPL) begin
				oval_q  <= gv;
				omask_q <= gm;
			end else begin
				oval_q  <= '0;
				omask_q <= '0;
			end
		end
	end

	assign res_out.valid      = ov_q;
	assign res_out.term_value = oval_q;
	assign res_out.term_mask  = omask_q;
	assign res_out.term_kind  = okind_q;
	assign res_out.last_term  = olast_q;
endmodule

// File: design/prime_implicant_generator.sv
// top level of the prime implicant generator
// A truth table of up to four variables enters as one request and leaves as its
// prime implicants, one per result, ordered by don't-care mask and then by value,
// the final one flagged by last_term. Every merge level is kept, so no prime is
// lost. A table that is zero (or one) on every minterm in use gives a single
// constant result with value and mask zero. num_vars (apb offset 0, reset 4)
// selects how many variables are in use: 0 acts as 1, values above 4 act as 4,
// and table bits past 2**num_vars are ignored. The analysis runs in three
// pipeline stages (table prep, implicant grid, prime grid) followed by a
// serializer that drains one prime per cycle into an output register while
// res_out is ready. The serializer sets the rate: a table gives max(1, number
// of primes) results, at most 32, while the next table moves through the
// analysis stages behind it.
module prime_implicant_generator import pig_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// apb configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// request and result channels
	pig_in_if.sink             req_in,
	pig_out_if.source          res_out
);
	logic [NV_W-1:0] num_vars;
	logic            item_valid;
	logic            item_ready;
	pig_item_t       item;

	// register file
	pig_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.num_vars (num_vars)
	);

	// implicant and prime grids, one request per cycle while the serializer takes items
	pig_cube u_cube (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_vars   (num_vars),
		.req_in     (req_in),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	// one prime per cycle out of the grid while res_out is ready
	pig_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_out    (res_out)
	);
endmodule
